[rtl/lldq_pkg.sv]
// Package for the linked-list deque pool: payload structs, command and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package lldq_pkg;

  localparam int NODES_DEF     = 128;
  localparam int DATA_BITS_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int HDL_W  = 7;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_TAIL  = 3'd1,
    CMD_POP_HEAD   = 3'd2,
    CMD_INSERT     = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_FIND       = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] value_in;
    logic [HDL_W-1:0]        node_handle;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [HDL_W-1:0]        handle_out;
    logic [STAT_W-1:0]       status;
    logic [CNT_W-1:0]        item_total;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_INS_A,
    S_INS_B,
    S_INS_C,
    S_INS_D,
    S_INS_E,
    S_RM_A,
    S_RM_B,
    S_RM_C,
    S_RM_D,
    S_FIND_CHK,
    S_FIND_CAP,
    S_DONE
  } state_t;

  // Source of the working node pointer when a command is decoded.
  typedef enum logic [1:0] {
    P_ZERO,
    P_TAIL,
    P_HEAD,
    P_HANDLE
  } p_sel_t;

  // Link-memory write groups.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_INS1,
    WR_INS2,
    WR_RM1,
    WR_RM2
  } wr_sel_t;

  typedef struct packed {
    logic    req_load;
    logic    dec_load;
    p_sel_t  p_sel;
    logic    rd_free;
    logic    cap_fn;
    logic    cap_nx;
    logic    cap_pv;
    logic    cap_val;
    wr_sel_t wr_sel;
    logic    walk_step;
    logic    hout_p;
    logic    out_load;
    stat_t   status;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             hdl_zero;
    logic             pos_oor;
    logic             k_zero;
    logic             init_last;
  } dp_stat_t;

endpackage

[rtl/linked_list_deque_pool.sv]
// Each command is sequenced through controller states, one link-memory access per step
// through its registered read port; find walks position nodes from the head, and
// rejected or unused commands go from decode straight to the output register. One
// command at a time: the next transaction is accepted once the result is in the
// output register and the controller is back in idle. Synchronous reset; afterwards
// a sweep over all NODES link entries chains the free list while in_ready stays low.
module linked_list_deque_pool #(
  parameter int NODES     = lldq_pkg::NODES_DEF,
  parameter int DATA_BITS = lldq_pkg::DATA_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lldq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lldq_pkg::out_item_t out_data
);
  import lldq_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;

  lldq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lldq_dpath #(.NODES(NODES), .DATA_BITS(DATA_BITS)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctrl     (ctrl),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

[rtl/lldq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lldq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/lldq_ctrl.sv]
// Controller state machine of the linked-list deque pool: sequences the init sweep,
// the insert, remove and find steps, and the output register. Depends on lldq_pkg.
module lldq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lldq_pkg::dp_stat_t stat,
  output lldq_pkg::ctrl_t    ctrl
);
  import lldq_pkg::*;

  state_t state_r, state_nxt;
  stat_t  st_r, st_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      st_r        <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    ctrl        = '0;
    ctrl.status = st_r;
    state_nxt   = state_r;
    st_nxt      = st_r;
    in_ready    = 1'b0;
    case (state_r)
      S_INIT: begin
        ctrl.wr_sel = WR_INIT;
        if (stat.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.req_load = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl.dec_load = 1'b1;
        st_nxt        = STAT_OK;
        case (stat.cmd)
          CMD_PUSH_FRONT: begin
            ctrl.p_sel = P_ZERO;
            if (stat.full) begin
              st_nxt    = STAT_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_INS_A;
            end
          end
          CMD_PUSH_TAIL: begin
            ctrl.p_sel = P_TAIL;
            if (stat.full) begin
              st_nxt    = STAT_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_INS_A;
            end
          end
          CMD_INSERT: begin
            ctrl.p_sel = P_HANDLE;
            if (stat.full) begin
              st_nxt    = STAT_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_INS_A;
            end
          end
          CMD_POP_HEAD: begin
            ctrl.p_sel = P_HEAD;
            if (stat.empty) begin
              st_nxt    = STAT_EMPTY;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RM_A;
            end
          end
          CMD_DELETE: begin
            ctrl.p_sel = P_HANDLE;
            if (stat.empty) begin
              st_nxt    = STAT_EMPTY;
              state_nxt = S_DONE;
            end else if (stat.hdl_zero) begin
              st_nxt    = STAT_RANGE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RM_A;
            end
          end
          CMD_FIND: begin
            ctrl.p_sel = P_HEAD;
            if (stat.pos_oor) begin
              st_nxt    = STAT_RANGE;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_FIND_CHK;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_INS_A: begin
        ctrl.rd_free = 1'b1;
        state_nxt    = S_INS_B;
      end
      S_INS_B: begin
        ctrl.cap_fn = 1'b1;
        state_nxt   = S_INS_C;
      end
      S_INS_C: begin
        ctrl.cap_nx = 1'b1;
        state_nxt   = S_INS_D;
      end
      S_INS_D: begin
        ctrl.wr_sel = WR_INS1;
        state_nxt   = S_INS_E;
      end
      S_INS_E: begin
        ctrl.wr_sel = WR_INS2;
        state_nxt   = S_DONE;
      end
      S_RM_A: begin
        state_nxt = S_RM_B;
      end
      S_RM_B: begin
        ctrl.cap_nx  = 1'b1;
        ctrl.cap_pv  = 1'b1;
        ctrl.cap_val = (stat.cmd == CMD_POP_HEAD);
        state_nxt    = S_RM_C;
      end
      S_RM_C: begin
        ctrl.wr_sel = WR_RM1;
        state_nxt   = S_RM_D;
      end
      S_RM_D: begin
        ctrl.wr_sel = WR_RM2;
        state_nxt   = S_DONE;
      end
      S_FIND_CHK: begin
        // The link of the current node is read in this cycle and taken in the next.
        if (stat.k_zero) begin
          ctrl.hout_p = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_FIND_CAP;
        end
      end
      S_FIND_CAP: begin
        ctrl.walk_step = 1'b1;
        state_nxt      = S_FIND_CHK;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = ctrl.out_load | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted transaction did not move to decode");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE && out_valid_r))
    else $error("finished result overwrote a pending output transaction");

  a_init_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT && !stat.init_last) |=> (state_r == S_INIT))
    else $error("free-list init sweep ended early");

endmodule

[rtl/lldq_dpath.sv]
// Datapath of the linked-list deque pool: link and value memories, list pointers,
// working registers and the output register. Depends on lldq_pkg and lldq_ram.
module lldq_dpath #(
  parameter int NODES     = lldq_pkg::NODES_DEF,
  parameter int DATA_BITS = lldq_pkg::DATA_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lldq_pkg::in_item_t  in_data,
  input  lldq_pkg::ctrl_t     ctrl,
  output lldq_pkg::dp_stat_t  stat,
  output lldq_pkg::out_item_t out_data
);
  import lldq_pkg::*;

  localparam int HB = $clog2(NODES);
  localparam int PW = (HB > POS_W) ? HB : POS_W;

  logic [HB-1:0] head_r, tail_r, free_r, count_r, init_addr_r;
  logic [HB-1:0] p_r, nx_r, pv_r, fn_r, hout_r;
  logic [POS_W-1:0] k_r;
  logic [DATA_BITS-1:0] vout_r;
  logic [CMD_W-1:0] req_cmd_r;
  logic [DATA_BITS-1:0] req_val_r;
  logic [HB-1:0] req_hdl_r;
  logic [POS_W-1:0] req_pos_r;
  out_item_t out_r;

  logic nxt_we, prv_we, val_we;
  logic [HB-1:0] nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
  logic [HB-1:0] prv_waddr, prv_wdata, prv_rdata;
  logic [HB-1:0] val_waddr;
  logic [DATA_BITS-1:0] val_wdata, val_rdata;
  logic [HB-1:0] init_chain;

  // Handles wrap into the pool; the table is built from constants.
  logic [HB-1:0] hmod_tab [2**HDL_W];
  for (genvar g = 0; g < 2**HDL_W; g++) begin : g_hmod
    assign hmod_tab[g] = HB'(g % NODES);
  end

  logic [DATA_BITS+VAL_W-1:0] val_ext;
  logic [DATA_BITS+VAL_W-1:0] vo_ext;
  logic [HB+HDL_W-1:0] hout_ext;
  logic [HB+CNT_W-1:0] cnt_ext;

  assign val_ext  = {{DATA_BITS{in_data.value_in[VAL_W-1]}}, in_data.value_in};
  assign vo_ext   = {{VAL_W{1'b0}}, vout_r};
  assign hout_ext = {{HDL_W{1'b0}}, hout_r};
  assign cnt_ext  = {{CNT_W{1'b0}}, count_r};

  // Reset chain of the free list: 1 -> 2 -> ... -> NODES-1 -> 0, sentinel links to 0.
  assign init_chain = (init_addr_r != '0 && init_addr_r != HB'(NODES - 1)) ?
                      init_addr_r + HB'(1) : '0;

  assign nxt_raddr = ctrl.rd_free ? free_r : p_r;

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = p_r;
    nxt_wdata = free_r;
    prv_we    = 1'b0;
    prv_waddr = nx_r;
    prv_wdata = free_r;
    val_we    = 1'b0;
    val_waddr = free_r;
    val_wdata = req_val_r;
    case (ctrl.wr_sel)
      WR_INIT: begin
        nxt_we    = 1'b1;
        nxt_waddr = init_addr_r;
        nxt_wdata = init_chain;
      end
      WR_INS1: begin
        nxt_we    = 1'b1;
        nxt_waddr = free_r;
        nxt_wdata = nx_r;
        prv_we    = 1'b1;
        prv_waddr = free_r;
        prv_wdata = p_r;
        val_we    = 1'b1;
      end
      WR_INS2: begin
        prv_we    = (nx_r != '0);
        prv_waddr = nx_r;
        prv_wdata = free_r;
        nxt_we    = (p_r != '0);
        nxt_waddr = p_r;
        nxt_wdata = free_r;
      end
      WR_RM1: begin
        prv_we    = (nx_r != '0);
        prv_waddr = nx_r;
        prv_wdata = pv_r;
        nxt_we    = (pv_r != '0);
        nxt_waddr = pv_r;
        nxt_wdata = nx_r;
      end
      WR_RM2: begin
        nxt_we    = 1'b1;
        nxt_waddr = p_r;
        nxt_wdata = free_r;
      end
      default: begin
        nxt_we = 1'b0;
      end
    endcase
  end

  lldq_ram #(.WIDTH(HB), .DEPTH(NODES)) u_nxt (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  lldq_ram #(.WIDTH(HB), .DEPTH(NODES)) u_prv (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (p_r),
    .rdata (prv_rdata)
  );

  lldq_ram #(.WIDTH(DATA_BITS), .DEPTH(NODES)) u_val (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (p_r),
    .rdata (val_rdata)
  );

  // List pointers; the sentinel's links live here rather than in memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= HB'(1);
      count_r     <= '0;
      init_addr_r <= '0;
    end else begin
      case (ctrl.wr_sel)
        WR_INIT: begin
          init_addr_r <= init_addr_r + HB'(1);
        end
        WR_INS2: begin
          if (nx_r == '0) begin
            tail_r <= free_r;
          end
          if (p_r == '0) begin
            head_r <= free_r;
          end
          free_r  <= fn_r;
          count_r <= count_r + HB'(1);
        end
        WR_RM1: begin
          if (nx_r == '0) begin
            tail_r <= pv_r;
          end
          if (pv_r == '0) begin
            head_r <= nx_r;
          end
        end
        WR_RM2: begin
          free_r <= p_r;
          if (count_r != '0) begin
            count_r <= count_r - HB'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.req_load) begin
      req_cmd_r <= in_data.command;
      req_val_r <= val_ext[DATA_BITS-1:0];
      req_hdl_r <= hmod_tab[in_data.node_handle];
      req_pos_r <= in_data.position;
      vout_r    <= '0;
      hout_r    <= '0;
    end
    if (ctrl.dec_load) begin
      k_r <= req_pos_r;
      case (ctrl.p_sel)
        P_ZERO:   p_r <= '0;
        P_TAIL:   p_r <= tail_r;
        P_HEAD:   p_r <= head_r;
        P_HANDLE: p_r <= req_hdl_r;
        default:  p_r <= '0;
      endcase
    end
    if (ctrl.walk_step) begin
      p_r <= nxt_rdata;
      k_r <= k_r - POS_W'(1);
    end
    if (ctrl.cap_fn) begin
      fn_r <= nxt_rdata;
    end
    if (ctrl.cap_nx) begin
      nx_r <= (p_r == '0) ? head_r : nxt_rdata;
    end
    if (ctrl.cap_pv) begin
      pv_r <= (p_r == '0) ? tail_r : prv_rdata;
    end
    if (ctrl.cap_val) begin
      vout_r <= val_rdata;
    end
    if (ctrl.hout_p) begin
      hout_r <= p_r;
    end
    if (ctrl.wr_sel == WR_INS2) begin
      hout_r <= free_r;
    end
    if (ctrl.out_load) begin
      out_r.value_out  <= $signed(vo_ext[VAL_W-1:0]);
      out_r.handle_out <= hout_ext[HDL_W-1:0];
      out_r.status     <= ctrl.status;
      out_r.item_total <= cnt_ext[CNT_W-1:0];
    end
  end

  assign stat.cmd       = req_cmd_r;
  assign stat.full      = (free_r == '0) || (count_r >= HB'(NODES - 1));
  assign stat.empty     = (count_r == '0);
  assign stat.hdl_zero  = (req_hdl_r == '0);
  assign stat.pos_oor   = (PW'(req_pos_r) >= PW'(count_r));
  assign stat.k_zero    = (k_r == '0);
  assign stat.init_last = (init_addr_r == HB'(NODES - 1));

  assign out_data = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= HB'(NODES - 1))
    else $error("list count beyond pool capacity");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.wr_sel == WR_INS2) |=> (count_r == $past(count_r) + HB'(1)))
    else $error("insert did not grow the list count");

  a_ins_node: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.wr_sel == WR_INS1) |-> (free_r != '0))
    else $error("insert took the sentinel from the free list");

  a_rm_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.wr_sel == WR_RM2) |=> (free_r == $past(p_r)))
    else $error("removed node not returned to the free list");

endmodule
